// ----- rtl/core/epoch_to_calendar_date_assert.svh -----
// Assertion helpers used by the conversion sequencer.
`ifndef EPOCH_TO_CALENDAR_DATE_ASSERT_SVH
`define EPOCH_TO_CALENDAR_DATE_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define ETCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("etcd: same-cycle check failed");

// Next-cycle implication, held off while reset is asserted.
`define ETCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("etcd: next-cycle check failed");

`endif

// ----- rtl/core/etcd_pkg.sv -----
`timescale 1ns / 1ps

package etcd_pkg;

    localparam int EPOCH_W   = 32;
    localparam int OFFSET_W  = 17;
    localparam int DAYS_W    = 16;
    localparam int SUM_W     = EPOCH_W + 2;

    localparam logic [EPOCH_W-1:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [EPOCH_W-1:0] SECS_PER_HOUR = 32'd3600;
    localparam logic [EPOCH_W-1:0] SECS_PER_MIN  = 32'd60;

    localparam logic [3:0] DAY_STEPS  = 4'd15;
    localparam logic [3:0] HOUR_STEPS = 4'd4;
    localparam logic [3:0] MIN_STEPS  = 4'd5;

    // 1970 relative to 1900, and its residues for the leap rules
    localparam logic [7:0] EPOCH_YEAR_REL = 8'd70;
    localparam logic [1:0] EPOCH_MOD4     = 2'd2;
    localparam logic [6:0] EPOCH_MOD100   = 7'd70;
    localparam logic [8:0] EPOCH_MOD400   = 9'd370;
    localparam logic [2:0] EPOCH_WEEKDAY  = 3'd4;

    localparam logic [3:0] MONTH_FEB = 4'd1;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day_of_month;
        logic [3:0] month_index;
        logic [7:0] years_since_1900;
        logic [8:0] day_of_year;
        logic [2:0] weekday;
        logic       range_error;
    } t_result;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month) inside
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // Residue mod 7 by folding octal digits (8 is 1 mod 7).
    function automatic logic [2:0] mod7(input logic [DAYS_W:0] v);
        logic [5:0] f1;
        logic [3:0] f2;
        f1 = {3'b0, v[2:0]} + {3'b0, v[5:3]} + {3'b0, v[8:6]} + {3'b0, v[11:9]}
           + {3'b0, v[14:12]} + {4'b0, v[16:15]};
        f2 = {1'b0, f1[2:0]} + {1'b0, f1[5:3]};
        if (f2 >= 4'd7) begin
            f2 = f2 - 4'd7;
        end
        return f2[2:0];
    endfunction

endpackage

// ----- rtl/core/etcd_if.sv -----
`timescale 1ns / 1ps

interface etcd_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] epoch_seconds;

    modport source(output valid, output func, output epoch_seconds, input ready);
    modport sink(input valid, input func, input epoch_seconds, output ready);
endinterface

interface etcd_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day_of_month;
    logic [3:0] month_index;
    logic [7:0] years_since_1900;
    logic [8:0] day_of_year;
    logic [2:0] weekday;
    logic       range_error;

    modport source(output valid, output second, output minute, output hour,
                   output day_of_month, output month_index, output years_since_1900,
                   output day_of_year, output weekday, output range_error, input ready);
    modport sink(input valid, input second, input minute, input hour,
                 input day_of_month, input month_index, input years_since_1900,
                 input day_of_year, input weekday, input range_error, output ready);
endinterface

// ----- rtl/core/etcd_sub.sv -----
`timescale 1ns / 1ps

// Shared subtract and compare: diff = a - b, ge when a >= b.
module etcd_sub (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_diff,
    output logic        o_ge
);
    logic [32:0] w_full;

    assign w_full = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_full[31:0];
    assign o_ge   = ~w_full[32];
endmodule

// ----- rtl/core/etcd_seq.sv -----
`timescale 1ns / 1ps
`include "epoch_to_calendar_date_assert.svh"

module etcd_seq (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_func,
    input  logic [31:0]             i_epoch_seconds,
    input  logic [16:0]             i_offset,
    input  logic                    i_take,
    output logic                    o_ready,
    output logic                    o_done,
    output etcd_pkg::t_result       o_result
);
    typedef enum logic [2:0] {
        S_IDLE, S_DAY, S_HOUR, S_MIN, S_WDAY, S_YEAR, S_MONTH, S_DONE
    } t_state;

    t_state      r_state, n_state;
    logic [3:0]  r_step, n_step;
    logic [31:0] r_rem, n_rem;
    logic [15:0] r_days, n_days;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_minute, n_minute;
    logic [2:0]  r_wday, n_wday;
    logic [7:0]  r_year, n_year;
    logic [1:0]  r_c4, n_c4;
    logic [6:0]  r_c100, n_c100;
    logic [8:0]  r_c400, n_c400;
    logic [3:0]  r_month, n_month;
    logic [8:0]  r_yday, n_yday;
    logic        r_err, n_err;

    logic [etcd_pkg::SUM_W-1:0] w_sum;
    logic [31:0] w_base, w_a, w_b, w_diff;
    logic        w_ge, w_leap;
    logic        w_date_ok, w_err_clear;

    assign w_sum = {2'b00, i_epoch_seconds}
                 + (i_func ? {{(etcd_pkg::SUM_W - etcd_pkg::OFFSET_W){i_offset[16]}}, i_offset}
                           : '0);

    assign w_leap = ((r_c4 == 2'd0) && (r_c100 != 7'd0)) || (r_c400 == 9'd0);

    always_comb begin
        w_base = '0;
        unique case (r_state)
            S_DAY:   w_base = etcd_pkg::SECS_PER_DAY;
            S_HOUR:  w_base = etcd_pkg::SECS_PER_HOUR;
            S_MIN:   w_base = etcd_pkg::SECS_PER_MIN;
            default: w_base = '0;
        endcase
    end

    always_comb begin
        w_a = r_rem;
        w_b = w_base << r_step;
        if (r_state == S_YEAR) begin
            w_a = {16'b0, r_days};
            w_b = w_leap ? 32'd366 : 32'd365;
        end else if (r_state == S_MONTH) begin
            w_a = {16'b0, r_days};
            w_b = {27'b0, etcd_pkg::month_len(r_month, w_leap)};
        end
    end

    etcd_sub u_sub (
        .i_a    (w_a),
        .i_b    (w_b),
        .o_diff (w_diff),
        .o_ge   (w_ge)
    );

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_rem    = r_rem;
        n_days   = r_days;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_wday   = r_wday;
        n_year   = r_year;
        n_c4     = r_c4;
        n_c100   = r_c100;
        n_c400   = r_c400;
        n_month  = r_month;
        n_yday   = r_yday;
        n_err    = r_err;
        unique case (r_state) inside
            S_IDLE: begin
                if (i_start) begin
                    n_err    = w_sum[33] | w_sum[32];
                    n_rem    = w_sum[31:0];
                    n_step   = etcd_pkg::DAY_STEPS;
                    n_days   = '0;
                    n_hour   = '0;
                    n_minute = '0;
                    n_year   = etcd_pkg::EPOCH_YEAR_REL;
                    n_c4     = etcd_pkg::EPOCH_MOD4;
                    n_c100   = etcd_pkg::EPOCH_MOD100;
                    n_c400   = etcd_pkg::EPOCH_MOD400;
                    n_month  = '0;
                    n_state  = (w_sum[33] | w_sum[32]) ? S_DONE : S_DAY;
                end
            end
            S_DAY, S_HOUR, S_MIN: begin
                if (w_ge) begin
                    n_rem = w_diff;
                end
                if (r_state == S_DAY) begin
                    n_days = {r_days[14:0], w_ge};
                end else if (r_state == S_HOUR) begin
                    n_hour = {r_hour[3:0], w_ge};
                end else begin
                    n_minute = {r_minute[4:0], w_ge};
                end
                n_step = r_step - 4'd1;
                if (r_step == 4'd0) begin
                    if (r_state == S_DAY) begin
                        n_state = S_HOUR;
                        n_step  = etcd_pkg::HOUR_STEPS;
                    end else if (r_state == S_HOUR) begin
                        n_state = S_MIN;
                        n_step  = etcd_pkg::MIN_STEPS;
                    end else begin
                        n_state = S_WDAY;
                    end
                end
            end
            S_WDAY: begin
                n_wday  = etcd_pkg::mod7({1'b0, r_days} + {14'b0, etcd_pkg::EPOCH_WEEKDAY});
                n_state = S_YEAR;
            end
            S_YEAR: begin
                if (w_ge) begin
                    n_days = w_diff[15:0];
                    n_year = r_year + 8'd1;
                    n_c4   = r_c4 + 2'd1;
                    n_c100 = (r_c100 == 7'd99)  ? 7'd0 : r_c100 + 7'd1;
                    n_c400 = (r_c400 == 9'd399) ? 9'd0 : r_c400 + 9'd1;
                end else begin
                    n_yday  = r_days[8:0];
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                if (w_ge) begin
                    n_days  = w_diff[15:0];
                    n_month = r_month + 4'd1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_step   <= n_step;
        r_rem    <= n_rem;
        r_days   <= n_days;
        r_hour   <= n_hour;
        r_minute <= n_minute;
        r_wday   <= n_wday;
        r_year   <= n_year;
        r_c4     <= n_c4;
        r_c100   <= n_c100;
        r_c400   <= n_c400;
        r_month  <= n_month;
        r_yday   <= n_yday;
        r_err    <= n_err;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_done  = (r_state == S_DONE);

    always_comb begin
        o_result = '0;
        o_result.range_error = r_err;
        if (!r_err) begin
            o_result.second           = r_rem[5:0];
            o_result.minute           = r_minute;
            o_result.hour             = r_hour;
            o_result.day_of_month     = r_days[4:0] + 5'd1;
            o_result.month_index      = r_month;
            o_result.years_since_1900 = r_year;
            o_result.day_of_year      = r_yday;
            o_result.weekday          = r_wday;
        end
    end

    assign w_date_ok   = (r_month <= 4'd11) && (r_days < 16'd31) && (r_wday <= 3'd6);
    assign w_err_clear = (o_result.years_since_1900 == 8'd0) && (o_result.day_of_month == 5'd0);

    `ETCD_ASSERT_NOW(a_date_sane, i_clk, i_rst_n, o_done && !r_err, w_date_ok)
    `ETCD_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_done && r_err, w_err_clear)
    `ETCD_ASSERT_NEXT(a_take_idle, i_clk, i_rst_n, o_done && i_take, r_state == S_IDLE)
    `ETCD_ASSERT_NOW(a_start_idle, i_clk, i_rst_n, i_start, r_state == S_IDLE)

endmodule

// ----- rtl/core/epoch_to_calendar_date.sv -----
`timescale 1ns / 1ps
// Sequence: a range error goes straight to the done state; otherwise the
//   sequencer steps day, hour and minute bits, the weekday, Y years past 1970
//   (0..136) and M months (0..11) on the shared subtractor. A new beat is taken
//   only from idle, once the last result has passed to the output register.
// Reset: synchronous, active low; clears the sequencer, output valid and local_offset.
module epoch_to_calendar_date (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic signed [16:0] i_cfg_wr_data,
    etcd_if.sink               i_in,
    etcd_out_if.source         o_out
);
    // Signed local offset, sign-extended into the adjust adder when func is set.
    logic [16:0]       r_local_offset;
    etcd_pkg::t_result r_out;
    logic              r_out_valid;

    logic              w_seq_ready;
    logic              w_seq_done;
    logic              w_take;
    etcd_pkg::t_result w_seq_result;

    // Hand a finished result to the output register whenever that slot is free
    // or being drained this cycle, so the sequencer can take the next beat.
    assign w_take = w_seq_done && (!r_out_valid || o_out.ready);

    assign i_in.ready = w_seq_ready;

    etcd_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_in.valid && w_seq_ready),
        .i_func          (i_in.func),
        .i_epoch_seconds (i_in.epoch_seconds),
        .i_offset        (r_local_offset),
        .i_take          (w_take),
        .o_ready         (w_seq_ready),
        .o_done          (w_seq_done),
        .o_result        (w_seq_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_offset <= '0;
        end else if (i_cfg_wr_en) begin
            // Hold the raw two's complement pattern.
            r_local_offset <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            // Drop valid once the beat is taken.
            r_out_valid <= 1'b0;
        end
        if (w_take) begin
            r_out <= w_seq_result;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.second           = r_out.second;
    assign o_out.minute           = r_out.minute;
    assign o_out.hour             = r_out.hour;
    assign o_out.day_of_month     = r_out.day_of_month;
    assign o_out.month_index      = r_out.month_index;
    assign o_out.years_since_1900 = r_out.years_since_1900;
    assign o_out.day_of_year      = r_out.day_of_year;
    assign o_out.weekday          = r_out.weekday;
    assign o_out.range_error      = r_out.range_error;

endmodule
